/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk, with the check off while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition is never true on a rising edge of clk, with the check off while rst is high.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* design/vns_pkg.sv */
package vns_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SQRT_GUARD  = 16;
   localparam int WORD_W      = 32;
   localparam int T_W         = WORD_W - 1;
   localparam int LANES       = 3;
   localparam int SQ_W        = 2 * WORD_W;
   localparam int SQRT_STAGES = WORD_W + SQRT_GUARD;
   localparam int ROOT_W      = SQRT_STAGES;
   localparam int SREM_W      = ROOT_W + 2;
   localparam int REM_W       = ROOT_W;
   localparam int DIV_STAGES  = WORD_W;
   localparam int PROD_W      = WORD_W + T_W;
   localparam int MAG_DELAY   = SQRT_STAGES + 1;
   localparam int LEN_INDEX   = 2 + SQRT_STAGES;
   localparam int QUO_INDEX   = LEN_INDEX + 1 + DIV_STAGES;
   localparam int OUT_INDEX   = QUO_INDEX + 1;
   localparam int LATENCY     = OUT_INDEX + 1;

   localparam logic [WORD_W-1:0] POS_MAX   = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] NEG_LIM   = 32'h8000_0000;
   localparam logic [WORD_W-1:0] ONE_FIXED = 32'd1 << FRAC_BITS;

   typedef struct packed {
      logic                     cmd;
      logic signed [WORD_W-1:0] in_x;
      logic signed [WORD_W-1:0] in_y;
      logic signed [WORD_W-1:0] in_z;
      logic [T_W-1:0]           target_length;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] out_x;
      logic signed [WORD_W-1:0] out_y;
      logic signed [WORD_W-1:0] out_z;
      logic                     was_zero;
      logic                     saturated;
   } rsp_type;

   // Per-item control that rides along with the data pipeline.
   typedef struct packed {
      logic             two_d;
      logic             zero;
      logic [T_W-1:0]   t;
      logic [LANES-1:0] neg;
   } meta_type;

endpackage

/* design/vector_normalize_scaled.sv */
// Each transferred item gives a result strobe that is high for a single cycle only.
// Throughput: one item per cycle; busy stays low because the receiver cannot stall.
// The depth is set by the 48-stage square root and the 32-stage divider in each lane.
// Reset clears only the valid bits of the pipeline; items in flight are dropped.
module vector_normalize_scaled (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vns_pkg::req_type req_data,
   output logic             rsp_strobe,
   output vns_pkg::rsp_type rsp_data
);
   import vns_pkg::*;

   // Valid bits and per-item control travel down the pipe next to the data.
   logic                         valid_ff [0:QUO_INDEX];
   meta_type                     meta_ff  [0:QUO_INDEX];
   logic signed [WORD_W-1:0]     comp_ff  [LANES];
   meta_type                     meta_in;
   logic signed [WORD_W-1:0]     z_eff;
   logic [LANES-1:0][SQ_W-1:0]   square;
   logic [LANES-1:0][WORD_W-1:0] quo;
   logic [ROOT_W-1:0]            len;
   logic                         transfer;

   // The pipeline never holds off an item, so every start is a transfer.
   assign busy     = 1'b0;
   assign transfer = start & ~busy;

   // In two-component mode the z lane works on zero, which leaves the
   // z square and the z quotient at zero.
   assign z_eff = req_data.cmd ? '0 : req_data.in_z;

   always_comb begin
      meta_in.two_d = req_data.cmd;
      meta_in.t     = req_data.target_length;
      meta_in.neg   = {z_eff[WORD_W-1], req_data.in_y[WORD_W-1], req_data.in_x[WORD_W-1]};
      // The sum of squares is zero exactly when every component is zero.
      meta_in.zero  = (req_data.in_x == '0) && (req_data.in_y == '0) && (z_eff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= transfer;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= meta_in;
      comp_ff[0] <= req_data.in_x;
      comp_ff[1] <= req_data.in_y;
      comp_ff[2] <= z_eff;
   end

   for (genvar k = 0; k < QUO_INDEX; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         meta_ff[k+1] <= meta_ff[k];
      end
   end

   // Each lane squares its component up front, then later scales it by
   // target over length with its own multiplier and divider.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      vns_lane u_lane (
         .clock  (clock),
         .comp   (comp_ff[l]),
         .target (meta_ff[LEN_INDEX].t),
         .len    (len),
         .square (square[l]),
         .quo    (quo[l])
      );
   end

   // The shared unit sums the squares and takes the scaled square root.
   vns_sqrt u_sqrt (
      .clock  (clock),
      .square (square),
      .len    (len)
   );

   // The merge stage applies signs, clipping and the special cases.
   vns_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .valid  (valid_ff[QUO_INDEX]),
      .meta   (meta_ff[QUO_INDEX]),
      .quo    (quo),
      .strobe (rsp_strobe),
      .rsp    (rsp_data)
   );

endmodule

/* design/vns_lane.sv */
module vns_lane (
   input  logic                             clock,
   input  logic signed [vns_pkg::WORD_W-1:0] comp,
   input  logic [vns_pkg::T_W-1:0]           target,
   input  logic [vns_pkg::ROOT_W-1:0]        len,
   output logic [vns_pkg::SQ_W-1:0]          square,
   output logic [vns_pkg::WORD_W-1:0]        quo
);
   import vns_pkg::*;

   logic [WORD_W-1:0]     comp_u;
   logic [WORD_W-1:0]     mag;
   logic [SQ_W-1:0]       square_ff;
   logic [WORD_W-1:0]     mag_ff [0:MAG_DELAY];
   logic [PROD_W-1:0]     prod;
   logic [REM_W-1:0]      rem_ff [0:DIV_STAGES];
   logic [DIV_STAGES-1:0] lo_ff  [0:DIV_STAGES];
   logic [WORD_W-1:0]     quo_ff [0:DIV_STAGES];
   logic [ROOT_W-1:0]     len_ff [0:DIV_STAGES];

   // Magnitude of the component; the most negative value maps to 2^31.
   assign comp_u = comp;
   assign mag    = comp_u[WORD_W-1] ? (WORD_W'(0) - comp_u) : comp_u;

   always_ff @(posedge clock) begin
      square_ff <= SQ_W'(mag) * SQ_W'(mag);
      mag_ff[0] <= mag;
   end

   for (genvar k = 0; k < MAG_DELAY; k++) begin : g_mag
      always_ff @(posedge clock) begin
         mag_ff[k+1] <= mag_ff[k];
      end
   end

   assign square = square_ff;

   // The quotient is known to fit one word, so the division starts with the
   // upper part of the shifted dividend already in the remainder.
   assign prod = PROD_W'(mag_ff[MAG_DELAY]) * PROD_W'(target);

   always_ff @(posedge clock) begin
      rem_ff[0] <= REM_W'(prod >> (DIV_STAGES - SQRT_GUARD));
      lo_ff[0]  <= DIV_STAGES'(prod << SQRT_GUARD);
      quo_ff[0] <= '0;
      len_ff[0] <= len;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [REM_W:0] rem_sh;
      logic [REM_W:0] len_w;
      logic           ge;

      always_comb begin
         rem_sh = {rem_ff[k], lo_ff[k][DIV_STAGES-1]};
         len_w  = {1'b0, len_ff[k]};
         ge     = (rem_sh >= len_w);
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? REM_W'(rem_sh - len_w) : REM_W'(rem_sh);
         lo_ff[k+1]  <= {lo_ff[k][DIV_STAGES-2:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][WORD_W-2:0], ge};
         len_ff[k+1] <= len_ff[k];
      end
   end

   assign quo = quo_ff[DIV_STAGES];

endmodule

/* design/vns_sqrt.sv */
module vns_sqrt (
   input  logic                                          clock,
   input  logic [vns_pkg::LANES-1:0][vns_pkg::SQ_W-1:0]  square,
   output logic [vns_pkg::ROOT_W-1:0]                    len
);
   import vns_pkg::*;

   logic [SQ_W-1:0]   s_ff    [0:SQRT_STAGES];
   logic [SREM_W-1:0] rem_ff  [0:SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [0:SQRT_STAGES];

   // Sum of squares fits 64 bits: three squares of at most 2^62 each.
   always_ff @(posedge clock) begin
      s_ff[0]    <= square[0] + square[1] + square[2];
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   // One root bit per stage, most significant first.
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam int I = SQRT_STAGES - 1 - k;
      logic [1:0]        pair;
      logic [SREM_W+1:0] rem_sh;
      logic [SREM_W+1:0] trial;
      logic              ge;

      if (I >= SQRT_GUARD) begin : g_pair
         assign pair = s_ff[k][2*(I-SQRT_GUARD) +: 2];
      end else begin : g_guard
         assign pair = 2'b00;
      end

      always_comb begin
         rem_sh = {rem_ff[k], pair};
         trial  = (SREM_W+2)'({root_ff[k], 2'b01});
         ge     = (rem_sh >= trial);
      end

      always_ff @(posedge clock) begin
         s_ff[k+1]    <= s_ff[k];
         rem_ff[k+1]  <= ge ? SREM_W'(rem_sh - trial) : SREM_W'(rem_sh);
         root_ff[k+1] <= {root_ff[k][ROOT_W-2:0], ge};
      end
   end

   assign len = root_ff[SQRT_STAGES];

endmodule

/* design/vns_merge.sv */
module vns_merge (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           valid,
   input  vns_pkg::meta_type                              meta,
   input  logic [vns_pkg::LANES-1:0][vns_pkg::WORD_W-1:0] quo,
   output logic                                           strobe,
   output vns_pkg::rsp_type                               rsp
);
   import vns_pkg::*;

   logic [LANES-1:0][WORD_W-1:0] val;
   logic [LANES-1:0]             clip;
   logic                         strobe_ff;
   rsp_type                      rsp_ff;
   rsp_type                      rsp_in;

   // Sign and clipping per lane.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         clip[l] = 1'b0;
         if (meta.neg[l]) begin
            if (quo[l] > NEG_LIM) begin
               val[l]  = NEG_LIM;
               clip[l] = 1'b1;
            end else begin
               val[l] = WORD_W'(0) - quo[l];
            end
         end else if (quo[l] > POS_MAX) begin
            val[l]  = POS_MAX;
            clip[l] = 1'b1;
         end else begin
            val[l] = quo[l];
         end
      end
   end

   always_comb begin
      rsp_in          = '0;
      rsp_in.was_zero = meta.zero;
      priority if (meta.zero) begin
         if (meta.two_d) begin
            rsp_in.out_x = (meta.t != '0) ? ONE_FIXED : '0;
         end else begin
            rsp_in.out_x = {1'b0, meta.t};
         end
      end else if (meta.t != '0) begin
         rsp_in.out_x     = val[0];
         rsp_in.out_y     = val[1];
         rsp_in.out_z     = meta.two_d ? '0 : val[2];
         rsp_in.saturated = clip[0] | clip[1] | (clip[2] & ~meta.two_d);
      end else begin
         rsp_in.out_x = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign strobe = strobe_ff;
   assign rsp    = rsp_ff;

endmodule

/* design/vns_checker.sv */
`include "assert_macros.svh"

module vns_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input vns_pkg::req_type req_data,
   input logic             rsp_strobe,
   input vns_pkg::rsp_type rsp_data
);
   import vns_pkg::*;

   `ASSERT_NEVER(a_never_busy, clock, reset, busy, "busy raised")
   `ASSERT_CLK(a_latency, clock, reset, (start && !busy) |-> ##LATENCY rsp_strobe, "result missing")
   `ASSERT_CLK(a_zero_vec, clock, reset, (rsp_strobe && rsp_data.was_zero) |-> (rsp_data.out_y == '0 && rsp_data.out_z == '0 && !rsp_data.saturated), "bad fallback")
   `ASSERT_CLK(a_two_d_z, clock, reset, (rsp_strobe && $past(start && !busy && req_data.cmd, LATENCY)) |-> (rsp_data.out_z == '0), "z set in 2D")

endmodule

bind vector_normalize_scaled vns_checker u_vns_checker (.*);

/* dv/vector_normalize_scaled_test.sv */
`timescale 1ns / 1ps

module vector_normalize_scaled_test;
   import vns_pkg::*;

   // The block has no configuration registers and keeps no state between items, so the bench is a
   // straight stream of vectors with a scaling predictor and an in-order check.

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   vector_normalize_scaled uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Scaled vectors still in flight, oldest first.
   rsp_type pending_vectors[$];
   int      error_count = 0;

   // Square root of the exact sum of squares, with SQRT_GUARD extra fraction bits.
   // The sum is shifted up by twice the guard, so the root fits in 48 bits.
   function automatic logic [63:0] guarded_root(logic [63:0] sum_sq);
      logic [127:0] radicand;
      logic [63:0]  root;
      logic [127:0] trial;
      radicand = {64'd0, sum_sq} << (2 * SQRT_GUARD);
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = {64'd0, root | (64'd1 << b)};
         if (trial * trial <= radicand) root = root | (64'd1 << b);
      end
      return root;
   endfunction

   // One component times target over length, truncated toward zero, then clipped.
   function automatic logic [31:0] scale_component(logic signed [31:0] comp,
                                                   logic [30:0] target,
                                                   logic [63:0] len,
                                                   ref logic clipped);
      logic [63:0]  mag;
      logic [127:0] quo;
      mag = comp[31] ? 64'd0 - {{32{comp[31]}}, comp} : {32'd0, comp};
      quo = (({64'd0, mag} * {97'd0, target}) << SQRT_GUARD) / {64'd0, len};
      if (comp[31]) begin
         if (quo > 128'h8000_0000) begin
            quo = 128'h8000_0000;
            clipped = 1'b1;
         end
         return 32'd0 - quo[31:0];
      end
      if (quo > 128'h7FFF_FFFF) begin
         quo = 128'h7FFF_FFFF;
         clipped = 1'b1;
      end
      return quo[31:0];
   endfunction

   function automatic rsp_type scaled_vector(req_type v);
      rsp_type r;
      logic signed [31:0] z;
      logic [63:0] mx, my, mz, sum_sq, len;
      logic clipped;
      r = '0;
      clipped = 1'b0;
      z = v.cmd ? 32'sd0 : v.in_z;
      mx = v.in_x[31] ? 64'd0 - {{32{1'b1}}, v.in_x} : {32'd0, v.in_x};
      my = v.in_y[31] ? 64'd0 - {{32{1'b1}}, v.in_y} : {32'd0, v.in_y};
      mz = z[31] ? 64'd0 - {{32{1'b1}}, z} : {32'd0, z};
      sum_sq = mx * mx + my * my + mz * mz;
      r.was_zero = (sum_sq == 0);
      if (r.was_zero) begin
         // A zero vector falls back to the x axis: target length in 3D, unity in 2D unless the target is zero.
         if (v.cmd) r.out_x = (v.target_length != 0) ? ONE_FIXED : '0;
         else r.out_x = {1'b0, v.target_length};
      end else if (v.target_length != 0) begin
         len = guarded_root(sum_sq);
         r.out_x = scale_component(v.in_x, v.target_length, len, clipped);
         r.out_y = scale_component(v.in_y, v.target_length, len, clipped);
         if (!v.cmd) r.out_z = scale_component(z, v.target_length, len, clipped);
      end
      r.saturated = clipped;
      return r;
   endfunction

   // Results are sampled at the edge that ends the strobe cycle; stimulus changes
   // are nonblocking, so there is no race with the block's own registers.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_vectors.size() == 0) begin
            $error("result transfer with no expected vector: %h", rsp_data);
            error_count++;
         end else begin
            want = pending_vectors.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x expected %h actual %h", want.out_x, rsp_data.out_x);
               error_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y expected %h actual %h", want.out_y, rsp_data.out_y);
               error_count++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $error("out_z expected %h actual %h", want.out_z, rsp_data.out_z);
               error_count++;
            end
            if (rsp_data.was_zero !== want.was_zero) begin
               $error("was_zero expected %b actual %b", want.was_zero, rsp_data.was_zero);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %b actual %b", want.saturated,
                      rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   // Directed rows. Where has_result is set, the result is typed in because it can
   // be read straight off the special cases; other rows go through the predictor.
   typedef struct {
      req_type item;
      bit      has_result;
      rsp_type result;
   } directed_row;

   directed_row directed_rows[$];

   function automatic req_type make_item(logic mode, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [30:0] t);
      req_type v;
      v.cmd = mode;
      v.in_x = x;
      v.in_y = y;
      v.in_z = z;
      v.target_length = t;
      return v;
   endfunction

   function automatic rsp_type make_result(logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic zero, logic sat);
      rsp_type r;
      r.out_x = x;
      r.out_y = y;
      r.out_z = z;
      r.was_zero = zero;
      r.saturated = sat;
      return r;
   endfunction

   task automatic add_row(req_type v, bit known, rsp_type r);
      directed_row row;
      row.item = v;
      row.has_result = known;
      row.result = r;
      directed_rows.push_back(row);
   endtask

   // Drives one item and holds it until the block takes it. Gaps are inserted
   // before raising start; start stays high across back-to-back transfers.
   task automatic send_vector(req_type v, bit known, rsp_type r, bit allow_gaps);
      if (allow_gaps) begin
         while ($urandom_range(99) < 28) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_data <= v;
      do @(posedge clock); while (busy);
      pending_vectors.push_back(known ? r : scaled_vector(v));
   endtask

   // Random vectors, a third of the components of moderate size so that lengths vary widely,
   // the rest full-range words, the most negative word or minus one, tiny components, and zero parts.
   function automatic logic [31:0] random_component();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h8000_0000 | ($urandom_range(1) ? 32'h7FFF_FFFF : 32'd0);
         2: return $urandom_range(1) ? $urandom_range(15) : 32'd0 - $urandom_range(15);
         3: return 32'd0;
         default: return $signed($urandom()) >>> $urandom_range(20);
      endcase
   endfunction

   function automatic logic [30:0] random_target();
      case ($urandom_range(4))
         0: return 31'h0001_0000;
         1: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
         2: return 31'($urandom_range(255));
         default: return 31'($urandom() >> $urandom_range(1, 16));
      endcase
   endfunction

   initial begin
      req_type v;
      rsp_type none;
      none = '0;

      // Zero vector fallbacks in both modes, with zero and nonzero targets.
      add_row(make_item(1'b0, 0, 0, 0, 31'h0001_0000), 1,
              make_result(32'h0001_0000, 0, 0, 1'b1, 1'b0));
      add_row(make_item(1'b0, 0, 0, 0, 31'h7FFF_FFFF), 1,
              make_result(32'h7FFF_FFFF, 0, 0, 1'b1, 1'b0));
      add_row(make_item(1'b1, 0, 0, 0, 31'h0003_0000), 1,
              make_result(32'h0001_0000, 0, 0, 1'b1, 1'b0));
      add_row(make_item(1'b1, 0, 0, 32'h7FFF_FFFF, 31'h0003_0000), 1,
              make_result(32'h0001_0000, 0, 0, 1'b1, 1'b0));
      add_row(make_item(1'b1, 0, 0, 0, 0), 1, make_result(0, 0, 0, 1'b1, 1'b0));
      add_row(make_item(1'b0, 0, 0, 0, 0), 1, make_result(0, 0, 0, 1'b1, 1'b0));
      // A zero target with a nonzero vector gives the zero vector.
      add_row(make_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0), 1,
              make_result(0, 0, 0, 1'b0, 1'b0));
      // Axis vectors scale exactly to the target.
      add_row(make_item(1'b0, 32'h0002_0000, 0, 0, 31'h0001_0000), 1,
              make_result(32'h0001_0000, 0, 0, 1'b0, 1'b0));
      add_row(make_item(1'b1, 0, 32'hFFFF_0000, 32'h1234_5678, 31'h7FFF_FFFF), 1,
              make_result(0, 32'h8000_0001, 0, 1'b0, 1'b0));
      add_row(make_item(1'b0, 0, 0, 32'h8000_0000, 31'h0000_0001), 1,
              make_result(0, 0, 32'hFFFF_FFFF, 1'b0, 1'b0));
      // Extremes of every component and of the target, through the predictor.
      add_row(make_item(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        31'h7FFF_FFFF), 0, none);
      add_row(make_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        31'h7FFF_FFFF), 0, none);
      add_row(make_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF), 0, none);
      add_row(make_item(1'b0, 32'h1, 32'hFFFF_FFFF, 32'h1, 31'h0001_0000), 0, none);
      add_row(make_item(1'b1, 32'h1, 32'h1, 32'hFFFF_FFFF, 31'h7FFF_FFFF), 0, none);
      add_row(make_item(1'b0, 32'h0003_0000, 32'h0004_0000, 0, 31'h0001_0000), 0, none);
      add_row(make_item(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0001,
                        31'h5555_5555), 0, none);
      add_row(make_item(1'b1, 32'hDEAD_BEEF, 32'h0000_0001, 32'h0, 31'h2AAA_AAAA), 0, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed rows go back to back, without gaps.
      foreach (directed_rows[i])
         send_vector(directed_rows[i].item, directed_rows[i].has_result,
                     directed_rows[i].result, 1'b0);

      // Random part; items 400 to 599 form a stretch with no gaps at all.
      for (int n = 0; n < 1050; n++) begin
         v.cmd = 1'($urandom_range(1));
         v.in_x = random_component();
         v.in_y = random_component();
         v.in_z = random_component();
         v.target_length = random_target();
         send_vector(v, 1'b0, none, !(n >= 400 && n < 600));
      end
      start <= 1'b0;

      // Wait for the pipeline to drain, then keep clocking before the final report.
      while (pending_vectors.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      if (error_count == 0)
         $display("** vector_normalize_scaled: PASSED **");
      else
         $display("** vector_normalize_scaled: FAILED **");
      $finish;
   end

   initial begin
      #2ms;
      $display("** vector_normalize_scaled: FAILED **");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/vns_pkg.sv
design/vns_lane.sv
design/vns_sqrt.sv
design/vns_merge.sv
design/vector_normalize_scaled.sv
design/vns_checker.sv
dv/vector_normalize_scaled_test.sv
